@@ rtl/core/pst_pkg.sv @@
// shared types and codes for the priority slot table
package pst_pkg;

	localparam int OP_W = 2;
	localparam int EV_W = 4;

	typedef logic [OP_W-1:0] opcode_t;
	typedef logic [EV_W-1:0] event_t;

	// request codes, the fourth code is ignored
	localparam opcode_t OP_ADD    = 2'd0;
	localparam opcode_t OP_REMOVE = 2'd1;
	localparam opcode_t OP_CLEAR  = 2'd2;

	// result event codes
	localparam event_t EV_REJECTED  = 4'd0;
	localparam event_t EV_DUPLICATE = 4'd1;
	localparam event_t EV_REPLACED  = 4'd2;
	localparam event_t EV_ADDED     = 4'd3;
	localparam event_t EV_CHANGED   = 4'd4;
	localparam event_t EV_REMOVED   = 4'd5;
	localparam event_t EV_EMPTY     = 4'd6;
	localparam event_t EV_NOT_FOUND = 4'd7;
	localparam event_t EV_CLEARED   = 4'd8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_ADDED,
		ST_CHANGED,
		ST_SCAN,
		ST_TOP
	} state_t;

endpackage

@@ rtl/core/priority_slot_table_top.sv @@
// priority slot table: one item slot per level and a highest active level register
//
// The block keeps one slot per priority level, each with a valid flag and an item id,
// and a signed register naming the highest occupied level (-1 when there is none).
// Each request beat (add, remove, clear; the fourth opcode is dropped without a result)
// gives one to three result beats, the final one flagged by last. Result beats go out
// only while the result side is not stalled. Item ids sit in a single-port memory with
// a registered read, so every decision waits for the slot read. Removing the top level
// walks the valid flags downward from the removed level, one level per cycle through a
// shared decrement and compare, then reads the new top item.
// No new request is taken while one is being worked on, but a request is taken while
// the last result beat of the previous one still waits in the output register.
// Clear empties every slot but keeps the top level register, which may then name an
// empty level until a later add or remove moves it. No clearing pass follows reset.
module priority_slot_table_top #(
	parameter int NUM_LEVELS = 32,
	parameter int ITEM_BITS = 16,
	localparam int LVL_W = $clog2(NUM_LEVELS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request side
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [pst_pkg::OP_W-1:0]    opcode,
	input  logic [LVL_W-1:0]            priority_req,
	input  logic [ITEM_BITS-1:0]        item_id,
	// result side
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [pst_pkg::EV_W-1:0]    event_res,
	output logic [ITEM_BITS-1:0]        event_item,
	output logic signed [LVL_W:0]       top_priority,
	output logic                        last
);

	import pst_pkg::*;

	// number of levels at level width plus one, for range checks
	localparam logic [LVL_W:0] NLV = (LVL_W+1)'(NUM_LEVELS);
	// step of one level for the downward walk
	localparam logic signed [LVL_W:0] LVL_ONE = (LVL_W+1)'(1);

	state_t state_q, state_d;

	// captured request beat
	opcode_t                op_q;
	logic [LVL_W-1:0]       lvl_q;
	logic [ITEM_BITS-1:0]   item_q;

	// slot store: valid flags in flops, item ids in memory
	logic [NUM_LEVELS-1:0]  valid_q;
	logic [ITEM_BITS-1:0]   mem [NUM_LEVELS];
	logic [ITEM_BITS-1:0]   rd_q;

	logic signed [LVL_W:0]  highest_q, highest_d;
	logic signed [LVL_W:0]  scan_q, scan_d;

	// output register
	logic                   out_valid_q;
	event_t                 ev_q;
	logic [ITEM_BITS-1:0]   ev_item_q;
	logic signed [LVL_W:0]  top_q;
	logic                   last_q;

	// decode and shared compare
	logic                   out_free;
	logic                   lvl_ok;
	logic                   in_lvl_ok;
	logic                   slot_hit;
	logic signed [LVL_W:0]  lvl_s;
	logic                   raise;
	logic                   is_top;
	logic                   in_op_known;
	logic [LVL_W-1:0]       scan_idx;

	// sequencer outputs
	logic                   emit_en;
	event_t                 emit_ev;
	logic [ITEM_BITS-1:0]   emit_item;
	logic                   emit_last;
	logic                   mem_re;
	logic [LVL_W-1:0]       mem_raddr;
	logic                   mem_we;
	logic                   set_v;
	logic                   clr_v;
	logic                   clr_all;
	logic                   highest_ld;
	logic                   scan_ld;

	assign out_free    = !out_valid_q || !out_stall;
	assign lvl_ok      = {1'b0, lvl_q} < NLV;
	assign in_lvl_ok   = {1'b0, priority_req} < NLV;
	assign slot_hit    = lvl_ok && valid_q[lvl_q];
	assign lvl_s       = $signed({1'b0, lvl_q});
	assign raise       = lvl_s >= highest_q;
	assign is_top      = lvl_s == highest_q;
	assign in_op_known = (opcode == OP_ADD) || (opcode == OP_REMOVE) || (opcode == OP_CLEAR);
	assign scan_idx    = scan_q[LVL_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_op_known) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (out_free) begin
					case (op_q)
						OP_ADD: begin
							if (item_q == '0 || !lvl_ok) begin
								state_d = ST_IDLE;
							end else if (slot_hit && rd_q == item_q) begin
								state_d = ST_IDLE;
							end else if (slot_hit) begin
								state_d = ST_ADDED;
							end else begin
								state_d = raise ? ST_CHANGED : ST_IDLE;
							end
						end
						OP_REMOVE: begin
							state_d = (slot_hit && is_top) ? ST_SCAN : ST_IDLE;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_ADDED: begin
				if (out_free) begin
					state_d = raise ? ST_CHANGED : ST_IDLE;
				end
			end
			ST_CHANGED: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (scan_q[LVL_W]) begin
					if (out_free) begin
						state_d = ST_IDLE;
					end
				end else if (valid_q[scan_idx]) begin
					state_d = ST_TOP;
				end
			end
			ST_TOP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs, every side effect goes with a result beat or a scan step
	always_comb begin
		in_stall   = 1'b1;
		emit_en    = 1'b0;
		emit_ev    = EV_CLEARED;
		emit_item  = '0;
		emit_last  = 1'b0;
		mem_re     = 1'b0;
		mem_raddr  = priority_req;
		mem_we     = 1'b0;
		set_v      = 1'b0;
		clr_v      = 1'b0;
		clr_all    = 1'b0;
		highest_ld = 1'b0;
		highest_d  = highest_q;
		scan_ld    = 1'b0;
		scan_d     = scan_q - LVL_ONE;
		case (state_q)
			ST_IDLE: begin
				in_stall  = 1'b0;
				mem_re    = in_valid && in_lvl_ok;
				mem_raddr = priority_req;
			end
			ST_DECIDE: begin
				emit_en = out_free;
				case (op_q)
					OP_ADD: begin
						if (item_q == '0 || !lvl_ok) begin
							emit_ev   = EV_REJECTED;
							emit_item = item_q;
							emit_last = 1'b1;
						end else if (slot_hit && rd_q == item_q) begin
							emit_ev   = EV_DUPLICATE;
							emit_item = item_q;
							emit_last = 1'b1;
						end else if (slot_hit) begin
							emit_ev   = EV_REPLACED;
							emit_item = rd_q;
						end else begin
							emit_ev   = EV_ADDED;
							emit_item = item_q;
							emit_last = !raise;
							mem_we    = out_free;
							set_v     = out_free;
						end
					end
					OP_REMOVE: begin
						if (!slot_hit) begin
							emit_ev   = EV_NOT_FOUND;
							emit_last = 1'b1;
						end else begin
							emit_ev   = EV_REMOVED;
							emit_item = rd_q;
							emit_last = !is_top;
							clr_v     = out_free;
							scan_ld   = out_free && is_top;
							scan_d    = lvl_s - LVL_ONE;
						end
					end
					default: begin
						emit_ev   = EV_CLEARED;
						emit_last = 1'b1;
						clr_all   = out_free;
					end
				endcase
			end
			ST_ADDED: begin
				emit_en   = out_free;
				emit_ev   = EV_ADDED;
				emit_item = item_q;
				emit_last = !raise;
				mem_we    = out_free;
				set_v     = out_free;
			end
			ST_CHANGED: begin
				emit_en    = out_free;
				emit_ev    = EV_CHANGED;
				emit_item  = item_q;
				emit_last  = 1'b1;
				highest_ld = out_free;
				highest_d  = lvl_s;
			end
			ST_SCAN: begin
				if (scan_q[LVL_W]) begin
					// walked past level zero, nothing left
					emit_en    = out_free;
					emit_ev    = EV_EMPTY;
					emit_last  = 1'b1;
					highest_ld = out_free;
					highest_d  = '1;
				end else if (valid_q[scan_idx]) begin
					mem_re    = 1'b1;
					mem_raddr = scan_idx;
				end else begin
					scan_ld = 1'b1;
				end
			end
			ST_TOP: begin
				emit_en    = out_free;
				emit_ev    = EV_CHANGED;
				emit_item  = rd_q;
				emit_last  = 1'b1;
				highest_ld = out_free;
				highest_d  = scan_q;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			highest_q   <= '1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_all) begin
				valid_q <= '0;
			end else if (set_v) begin
				valid_q[lvl_q] <= 1'b1;
			end else if (clr_v) begin
				valid_q[lvl_q] <= 1'b0;
			end
			if (highest_ld) begin
				highest_q <= highest_d;
			end
			if (emit_en) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request capture, scan counter and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			op_q   <= opcode;
			lvl_q  <= priority_req;
			item_q <= item_id;
		end
		if (scan_ld) begin
			scan_q <= scan_d;
		end
		if (emit_en) begin
			ev_q      <= emit_ev;
			ev_item_q <= emit_item;
			top_q     <= highest_ld ? highest_d : highest_q;
			last_q    <= emit_last;
		end
	end

	// item memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[lvl_q] <= item_q;
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	assign out_valid    = out_valid_q;
	assign event_res    = ev_q;
	assign event_item   = ev_item_q;
	assign top_priority = top_q;
	assign last         = last_q;

	// any occupied level above the top level register
	logic above_top;
	always_comb begin
		above_top = 1'b0;
		for (int i = 0; i < NUM_LEVELS; i++) begin
			if (valid_q[i] && ($signed((LVL_W+1)'(i)) > highest_q)) begin
				above_top = 1'b1;
			end
		end
	end

	a_no_slot_above_top: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CHANGED) |-> !above_top)
		else $error("occupied slot above top level");

	a_top_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!highest_q[LVL_W] |-> ({1'b0, highest_q[LVL_W-1:0]} < NLV))
		else $error("top level out of range");

	a_empty_clears_top: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_en && emit_ev == EV_EMPTY) |=> (out_valid && top_priority == '1 && last))
		else $error("empty beat without cleared top level");

endmodule
